/* hdl/mgrk_pkg.sv */
// Package for the delay chaotic series RK4 core: widths, constants, FSM states.
// No dependencies.
`default_nettype none
package mgrk_pkg;
    localparam int DEPTH_DEF = 256;
    localparam logic signed [31:0] RST_A  = 32'sd3355443;
    localparam logic signed [31:0] RST_B  = 32'sd1677722;
    localparam logic [30:0]        RST_H  = 31'd1677722;
    localparam logic signed [31:0] RST_X0 = 32'sd20132659;
    localparam logic [8:0]         RST_D  = 9'd170;
    localparam logic [47:0]        TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [31:0] Q_ONE = 32'sd16777216;
    localparam logic [31:0]        RECIP3 = 32'hAAAA_AAAB;

    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_H = 3'd2;
    localparam logic [2:0] REG_X0 = 3'd3;
    localparam logic [2:0] REG_D = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RDW, S_X2, S_X4, S_X8, S_X10, S_AXD, S_DIV, S_DIVW,
        S_BX, S_HF, S_KACC, S_SUM, S_DIV6, S_WB, S_OUT
    } t_state;

    typedef struct packed {
        logic   rd;
        logic   wb;
        logic   ld_xd;
        t_state op;
        logic   div_go;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last_stage;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] qrnd(input logic signed [63:0] p);
        logic signed [64:0] t;
        t = 65'(p) + 65'sd8388608;
        return 66'(t >>> 24);
    endfunction
endpackage
`default_nettype wire

/* hdl/mgrk_if.sv */
// Valid/ready channel interfaces for the core.
// Depends on nothing.
`default_nettype none
interface mgrk_in_if;
    logic valid;
    logic ready;
    logic advance;
    modport source(output valid, output advance, input ready);
    modport sink(input valid, input advance, output ready);
endinterface

interface mgrk_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_value;
    logic [47:0] elapsed_time;
    modport source(output valid, output sample_value, output elapsed_time, input ready);
    modport sink(input valid, input sample_value, input elapsed_time, output ready);
endinterface

interface mgrk_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/delay_chaotic_series_rk4_core.sv */
// Mackey-Glass series generator, RK4 step per accepted advance item.
// Channels: in (advance), out (sample_value, elapsed_time), cfg (index, data).
// An item with advance=1 starts one step; advance=0 is taken and dropped.
// Each step reads the delayed entry, forms its powers, then waits on the divider
// for the delayed term; the four RK4 stages follow on the shared multiplier,
// then sum/6 and writeback, after which out valid is raised.
// A new item is taken only once the previous step is done; it is taken while the
// result still waits in the output register, but only once that register can drain.
// Reset (synchronous, active low) loads register defaults and x0, zeroes time,
// pointer and the fill mark of the delay line. Entries at or above the fill
// mark read as zero, so the line needs no clearing pass.
// A stalled receiver holds the result and blocks the next advance=1 item;
// config and advance=0 items are still taken while idle.
// Config is taken only while idle.
`default_nettype none
module delay_chaotic_series_rk4_core #(
    parameter int DELAY_DEPTH = mgrk_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mgrk_in_if.sink    in_ch,
    mgrk_out_if.source out_ch,
    mgrk_cfg_if.sink   cfg_ch
);
    mgrk_pkg::t_cmd w_cmd;
    mgrk_pkg::t_sts w_sts;
    logic w_cap, w_cfg_rdy, w_in_rdy;
    logic [31:0] w_val, r_sv;
    logic [47:0] w_time;

    assign in_ch.ready  = w_in_rdy || (!in_ch.advance && w_cfg_rdy);
    assign cfg_ch.ready = w_cfg_rdy;

    mgrk_ctrl u_ctrl (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_in_valid (in_ch.valid), .i_advance (in_ch.advance),
        .o_in_ready (w_in_rdy), .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready), .o_cfg_ready (w_cfg_rdy),
        .o_cap (w_cap), .o_cmd (w_cmd), .i_sts (w_sts)
    );

    mgrk_dp #(.DEPTH (DELAY_DEPTH)) u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cmd (w_cmd), .o_sts (w_sts),
        .i_cfg_we (cfg_ch.valid && w_cfg_rdy), .i_cfg_idx (cfg_ch.index),
        .i_cfg_data (cfg_ch.data), .o_value (w_val), .o_time (w_time)
    );

    always_ff @(posedge i_clk) begin
        if (w_cap) r_sv <= w_val;
    end

    assign out_ch.sample_value = r_sv;
    assign out_ch.elapsed_time = w_time;
endmodule
`default_nettype wire

/* hdl/mgrk_div.sv */
// Restoring divider, one quotient bit per cycle, truncation toward zero.
// Depends on mgrk_pkg.
`default_nettype none
module mgrk_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [31:0] r_d;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;
    logic signed [65:0] w_res;

    always_comb begin
        w_sh  = {r_rem[63:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {33'd0, r_d}) begin
            n_rem = w_sh - {33'd0, r_d};
            n_q[0] = 1'b1;
        end
        w_res = r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
        o_quo = mgrk_pkg::sat32(w_res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_num[63] ? 64'(-i_num) : i_num;
            r_rem <= '0;
            r_d   <= i_den[31:0];
            r_neg <= i_num[63] ^ i_den[31];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end
endmodule
`default_nettype wire

/* hdl/mgrk_dp.sv */
// Datapath: shared multiplier, delay line memory, RK4 accumulators and divider.
// Depends on mgrk_pkg and mgrk_div.
`default_nettype none
module mgrk_dp #(
    parameter int DEPTH = mgrk_pkg::DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mgrk_pkg::t_cmd      i_cmd,
    output mgrk_pkg::t_sts           o_sts,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    output logic [31:0]              o_value,
    output logic [47:0]              o_time
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic signed [31:0] r_a, r_b, r_x;
    logic [30:0] r_h;
    logic [8:0]  r_dly;
    logic [AW-1:0] r_ptr;
    logic [LW-1:0] r_fill;
    logic [47:0] r_time;
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd, r_xd, r_x2, r_p, r_term, r_f, r_xs, r_nx;
    logic        r_rd_ok;
    logic signed [35:0] r_sum;
    logic signed [32:0] r_q6;
    logic [1:0]  r_stg;
    logic signed [31:0] r_k;
    logic signed [63:0] r_axd;
    logic [LW-1:0] w_len;
    logic        w_on;
    logic [AW-1:0] w_pa;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [31:0] w_pr;
    logic signed [31:0] w_den;
    logic        w_div_done;
    logic signed [31:0] w_quo;
    logic signed [31:0] w_half, w_stin;
    logic [35:0] w_mag;
    logic [64:0] w_p3;
    logic signed [32:0] w_q6;

    always_comb begin
        if ({23'd0, r_dly} > 32'(DEPTH)) w_len = LW'(DEPTH);
        else w_len = LW'(r_dly);
        w_on = (w_len != '0);
        w_pa = ({{(32-AW){1'b0}}, r_ptr} >= 32'(w_len)) ? '0 : r_ptr;
    end

    always_comb begin
        unique case (i_cmd.op)
            mgrk_pkg::S_X2:  begin w_ma = r_xd; w_mb = r_xd; end
            mgrk_pkg::S_X4:  begin w_ma = r_p;  w_mb = r_p;  end
            mgrk_pkg::S_X8:  begin w_ma = r_p;  w_mb = r_p;  end
            mgrk_pkg::S_X10: begin w_ma = r_p;  w_mb = r_x2; end
            mgrk_pkg::S_AXD: begin w_ma = r_a;  w_mb = r_xd; end
            mgrk_pkg::S_BX:  begin w_ma = r_b;  w_mb = r_xs; end
            mgrk_pkg::S_HF:  begin w_ma = $signed({1'b0, r_h}); w_mb = r_f; end
            default:         begin w_ma = '0;   w_mb = '0;   end
        endcase
        w_prod = w_ma * w_mb;
        w_pr   = mgrk_pkg::sat32(mgrk_pkg::qrnd(w_prod));
        w_den  = mgrk_pkg::sat32(66'(mgrk_pkg::Q_ONE) + 66'(r_p));
        w_half = 32'((33'(r_k) + 33'sd1) >>> 1);
        unique case (r_stg)
            2'd0, 2'd1: w_stin = mgrk_pkg::sat32(66'(r_x) + 66'(w_half));
            default:    w_stin = mgrk_pkg::sat32(66'(r_x) + 66'(r_k));
        endcase
        w_mag = r_sum[35] ? 36'(-r_sum) : 36'(r_sum);
        w_p3  = 65'(w_mag[33:1]) * 65'(mgrk_pkg::RECIP3);
        w_q6  = r_sum[35] ? -$signed({1'b0, w_p3[64:33]}) : $signed({1'b0, w_p3[64:33]});
        o_sts.last_stage = (r_stg == 2'd3);
        o_sts.div_done   = w_div_done;
        o_value = r_x;
        o_time  = r_time;
    end

    mgrk_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_go (i_cmd.div_go),
        .i_num (r_axd), .i_den (w_den),
        .o_done (w_div_done), .o_quo (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd    <= r_mem[w_pa];
            r_rd_ok <= ({{(32-AW){1'b0}}, w_pa} < 32'(r_fill));
        end
        if (i_cmd.wb && w_on) r_mem[w_pa] <= r_nx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_xd) begin
            r_xd <= (w_on && r_rd_ok) ? r_rd : 32'sd0;
            r_xs <= r_x;
            r_stg <= 2'd0;
            r_sum <= '0;
        end
        unique case (i_cmd.op)
            mgrk_pkg::S_X2:  begin r_p <= w_pr; r_x2 <= w_pr; end
            mgrk_pkg::S_X4, mgrk_pkg::S_X8, mgrk_pkg::S_X10: r_p <= w_pr;
            mgrk_pkg::S_AXD: r_axd <= w_prod;
            mgrk_pkg::S_DIVW: if (w_div_done) r_term <= w_quo;
            mgrk_pkg::S_BX:  r_f <= mgrk_pkg::sat32(66'(r_term) - mgrk_pkg::qrnd(w_prod));
            mgrk_pkg::S_HF:  r_k <= w_pr;
            mgrk_pkg::S_KACC: begin
                r_sum <= (r_stg == 2'd1 || r_stg == 2'd2) ?
                         r_sum + 36'(r_k) + 36'(r_k) : r_sum + 36'(r_k);
                r_xs  <= w_stin;
                r_stg <= r_stg + 2'd1;
            end
            mgrk_pkg::S_SUM:  r_q6 <= w_q6;
            mgrk_pkg::S_DIV6: r_nx <= mgrk_pkg::sat32(66'(r_x) + 66'(r_q6));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= mgrk_pkg::RST_A;
            r_b <= mgrk_pkg::RST_B;
            r_h <= mgrk_pkg::RST_H;
            r_x <= mgrk_pkg::RST_X0;
            r_dly <= mgrk_pkg::RST_D;
            r_ptr <= '0;
            r_fill <= '0;
            r_time <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mgrk_pkg::REG_A:  r_a <= i_cfg_data;
                mgrk_pkg::REG_B:  r_b <= i_cfg_data;
                mgrk_pkg::REG_H:  r_h <= i_cfg_data[30:0];
                mgrk_pkg::REG_X0: r_x <= i_cfg_data;
                mgrk_pkg::REG_D:  begin r_dly <= i_cfg_data[8:0]; r_ptr <= '0; end
                default: ;
            endcase
        end else if (i_cmd.wb) begin
            r_x <= r_nx;
            if (w_on) begin
                r_ptr <= ({{(32-AW){1'b0}}, w_pa} + 32'd1 == 32'(w_len)) ? '0 : w_pa + AW'(1);
                if ({{(32-AW){1'b0}}, w_pa} == 32'(r_fill)) r_fill <= r_fill + LW'(1);
            end
            if ({1'b0, r_time} + {18'd0, r_h} > {1'b0, mgrk_pkg::TIME_MAX})
                r_time <= mgrk_pkg::TIME_MAX;
            else r_time <= r_time + {17'd0, r_h};
        end
    end
endmodule
`default_nettype wire

/* hdl/mgrk_ctrl.sv */
// Controller FSM sequencing one RK4 step over the shared datapath.
// Depends on mgrk_pkg.
`default_nettype none
module mgrk_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_advance,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_cfg_ready,
    output logic                o_cap,
    output mgrk_pkg::t_cmd      o_cmd,
    input  wire mgrk_pkg::t_sts i_sts
);
    mgrk_pkg::t_state r_st, n_st;
    logic r_ov, n_ov;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mgrk_pkg::S_IDLE: if (i_in_valid && i_advance && (!r_ov || i_out_ready))
                n_st = mgrk_pkg::S_RD;
            mgrk_pkg::S_RD:   n_st = mgrk_pkg::S_RDW;
            mgrk_pkg::S_RDW:  n_st = mgrk_pkg::S_X2;
            mgrk_pkg::S_X2:   n_st = mgrk_pkg::S_X4;
            mgrk_pkg::S_X4:   n_st = mgrk_pkg::S_X8;
            mgrk_pkg::S_X8:   n_st = mgrk_pkg::S_X10;
            mgrk_pkg::S_X10:  n_st = mgrk_pkg::S_AXD;
            mgrk_pkg::S_AXD:  n_st = mgrk_pkg::S_DIV;
            mgrk_pkg::S_DIV:  n_st = mgrk_pkg::S_DIVW;
            mgrk_pkg::S_DIVW: if (i_sts.div_done) n_st = mgrk_pkg::S_BX;
            mgrk_pkg::S_BX:   n_st = mgrk_pkg::S_HF;
            mgrk_pkg::S_HF:   n_st = mgrk_pkg::S_KACC;
            mgrk_pkg::S_KACC: n_st = i_sts.last_stage ? mgrk_pkg::S_SUM : mgrk_pkg::S_BX;
            mgrk_pkg::S_SUM:  n_st = mgrk_pkg::S_DIV6;
            mgrk_pkg::S_DIV6: n_st = mgrk_pkg::S_WB;
            mgrk_pkg::S_WB:   n_st = mgrk_pkg::S_IDLE;
            default:          n_st = mgrk_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_st == mgrk_pkg::S_IDLE) && (!r_ov || i_out_ready);
        o_cfg_ready = (r_st == mgrk_pkg::S_IDLE);
        o_out_valid = r_ov;
        o_cap       = (r_st == mgrk_pkg::S_RD);
        o_cmd.rd     = (r_st == mgrk_pkg::S_RD);
        o_cmd.ld_xd  = (r_st == mgrk_pkg::S_RDW);
        o_cmd.wb     = (r_st == mgrk_pkg::S_WB);
        o_cmd.op     = r_st;
        o_cmd.div_go = (r_st == mgrk_pkg::S_DIV);
        n_ov = r_ov;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        if (r_st == mgrk_pkg::S_WB) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mgrk_pkg::S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end
endmodule
`default_nettype wire

/* hdl/mgrk_chk.sv */
// Port checker for the core, bound to the top level.
// Depends on delay_chaotic_series_rk4_core, the bind target.
`default_nettype none
module mgrk_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_ov,
    input wire logic        i_or,
    input wire logic [47:0] i_t,
    input wire logic        i_cr,
    input wire logic        i_cv
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ov && !i_or |=> i_ov) else $error("out valid dropped");
    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ov && !i_or |=> $stable(i_t)) else $error("time moved under stall");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cv && i_cr && i_ov && !i_or |=> i_ov) else $error("cfg lost result");
endmodule

bind delay_chaotic_series_rk4_core mgrk_chk u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ov (out_ch.valid),
    .i_or (out_ch.ready), .i_t (out_ch.elapsed_time),
    .i_cr (cfg_ch.ready), .i_cv (cfg_ch.valid)
);
`default_nettype wire
